### sv/pcxd_pkg.sv
// shared constants, types and codes of the pcx palette decoder
`default_nettype none
package pcxd_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int COORD_BITS = 16;
	localparam int PAL_AW = $clog2(PALETTE_DEPTH);

	localparam int CFG_W = 17;
	localparam int LB_W = 16;
	localparam int CNT_W = 17;
	localparam int RUN_W = 6;
	localparam int COLOR_W = 24;

	localparam logic [7:0] MARK_BITS = 8'hC0;
	localparam logic [RUN_W-1:0] COUNT_MASK = 6'h3F;

	localparam logic ACT_PALETTE = 1'b0;
	localparam logic ACT_CODE = 1'b1;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LINE_BYTES = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	typedef struct packed {
		logic accept;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic starts_run;
		logic run_over;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

### sv/pcx_rle_palette_decoder_core.sv
// top level of the pcx run-length palette decoder
// Input channel (in_valid/in_ready): each beat either loads one palette
// entry (action 0, palette_slot, palette_color) or feeds one compressed
// byte (action 1, code_byte). Output channel (out_valid/out_ready): one
// beat per visible pixel with its rgb color, column, row, run_last and
// image_done. The config port (cfg_we, cfg_index, cfg_data) sets width,
// height and line bytes; write it only while the block is idle.
// A palette load or a run marker is taken in idle. A literal is the palette
// ram read, then one column step. A run of n is the ram read of its color
// byte, then n column steps, or fewer when the line ends first; the column
// counter advances one column per cycle while the output is free, padding
// columns included. The first pixel appears on the output in the cycle after
// its step. Reset clears the counters and run state, sets the config registers
// to 1 and leaves the palette ram uncleared, holding garbage until loaded.
// When the receiver stalls, the pixel waits in the output register and the
// run pauses; new input is taken once the current run has been stepped out.
`default_nettype none
module pcx_rle_palette_decoder_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [pcxd_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              action,
	input  wire logic [7:0]                        palette_slot,
	input  wire logic [pcxd_pkg::COLOR_W-1:0]      palette_color,
	input  wire logic [7:0]                        code_byte,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [7:0]                             red,
	output logic [7:0]                             green,
	output logic [7:0]                             blue,
	output logic [pcxd_pkg::COORD_BITS-1:0]        column,
	output logic [pcxd_pkg::COORD_BITS-1:0]        row,
	output logic                                   run_last,
	output logic                                   image_done
);

	pcxd_pkg::cmd_t    cmd;
	pcxd_pkg::status_t st;

	pcxd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st      (st),
		.cmd     (cmd)
	);

	pcxd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.palette_slot (palette_slot),
		.palette_color(palette_color),
		.code_byte    (code_byte),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.column       (column),
		.row          (row),
		.run_last     (run_last),
		.image_done   (image_done)
	);

endmodule
`default_nettype wire

### sv/pcxd_ram.sv
// generic single-port ram with registered read
`default_nettype none
module pcxd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

### sv/pcxd_ctrl.sv
// controller state machine: idle accepts beats, run steps one column per cycle while the output is free
`default_nettype none
module pcxd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pcxd_pkg::status_t st,
	output pcxd_pkg::cmd_t        cmd
);

	pcxd_pkg::state_t state_q, state_d;

	always_comb begin
		in_ready = (state_q == pcxd_pkg::ST_IDLE);
		cmd.accept = in_valid && in_ready;
		cmd.step = (state_q == pcxd_pkg::ST_RUN) && st.out_free;
		state_d = state_q;
		unique case (state_q)
			pcxd_pkg::ST_IDLE: begin
				if (cmd.accept && st.starts_run) begin
					state_d = pcxd_pkg::ST_RUN;
				end
			end
			pcxd_pkg::ST_RUN: begin
				if (cmd.step && st.run_over) begin
					state_d = pcxd_pkg::ST_IDLE;
				end
			end
			default: state_d = pcxd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcxd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### sv/pcxd_datapath.sv
// datapath: config registers, palette, run and position counters, output register
`default_nettype none
module pcxd_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [pcxd_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                              action,
	input  wire logic [7:0]                        palette_slot,
	input  wire logic [pcxd_pkg::COLOR_W-1:0]      palette_color,
	input  wire logic [7:0]                        code_byte,
	input  wire pcxd_pkg::cmd_t                    cmd,
	output pcxd_pkg::status_t                      st,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [7:0]                             red,
	output logic [7:0]                             green,
	output logic [7:0]                             blue,
	output logic [pcxd_pkg::COORD_BITS-1:0]        column,
	output logic [pcxd_pkg::COORD_BITS-1:0]        row,
	output logic                                   run_last,
	output logic                                   image_done
);

	logic [pcxd_pkg::CFG_W-1:0] width_q, height_q;
	logic [pcxd_pkg::LB_W-1:0]  line_bytes_q;
	logic [pcxd_pkg::CNT_W-1:0] col_q, row_q;
	logic [pcxd_pkg::RUN_W-1:0] pend_q, rem_q;
	logic                       await_q, fin_q, idx_oob_q;

	logic                         is_code, marker, slot_oob, byte_oob;
	logic [pcxd_pkg::LB_W-1:0]    lb;
	logic [pcxd_pkg::CNT_W-1:0]   vis, x_inc, row_inc;
	logic                         row_done, emit, line_end, last_step;
	logic [pcxd_pkg::PAL_AW-1:0]  ram_addr;
	logic [pcxd_pkg::COLOR_W-1:0] ram_rdata, color;

	always_comb begin
		is_code = (action == pcxd_pkg::ACT_CODE);
		marker = ((code_byte & pcxd_pkg::MARK_BITS) == pcxd_pkg::MARK_BITS);
		slot_oob = ({1'b0, palette_slot} >= 9'(pcxd_pkg::PALETTE_DEPTH));
		byte_oob = ({1'b0, code_byte} >= 9'(pcxd_pkg::PALETTE_DEPTH));
		ram_addr = is_code ? code_byte[pcxd_pkg::PAL_AW-1:0]
		                   : palette_slot[pcxd_pkg::PAL_AW-1:0];

		lb = (line_bytes_q == '0) ? pcxd_pkg::LB_W'(1) : line_bytes_q;
		vis = (width_q < {1'b0, lb}) ? width_q : {1'b0, lb};

		row_done = (row_q >= height_q);
		x_inc = col_q + pcxd_pkg::CNT_W'(1);
		row_inc = row_q + pcxd_pkg::CNT_W'(1);
		emit = !row_done && (col_q < vis);
		line_end = !row_done && (x_inc >= {1'b0, lb});
		last_step = (rem_q == pcxd_pkg::RUN_W'(1));

		// a zero-length run is consumed without entering the run state
		st.starts_run = is_code && !fin_q && (await_q ? (pend_q != '0) : !marker);
		st.run_over = row_done || last_step || line_end;
		st.out_free = !out_valid || out_ready;

		color = idx_oob_q ? '0 : ram_rdata;
	end

	pcxd_ram #(
		.WIDTH(pcxd_pkg::COLOR_W),
		.DEPTH(pcxd_pkg::PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (cmd.accept && !is_code && !slot_oob),
		.re   (cmd.accept && is_code),
		.addr (ram_addr),
		.wdata(palette_color),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= pcxd_pkg::CFG_W'(1);
			height_q <= pcxd_pkg::CFG_W'(1);
			line_bytes_q <= pcxd_pkg::LB_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcxd_pkg::REG_WIDTH:      width_q <= cfg_data;
				pcxd_pkg::REG_HEIGHT:     height_q <= cfg_data;
				pcxd_pkg::REG_LINE_BYTES: line_bytes_q <= cfg_data[pcxd_pkg::LB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pend_q <= '0;
			rem_q <= '0;
			await_q <= 1'b0;
			fin_q <= 1'b0;
			idx_oob_q <= 1'b0;
		end else begin
			if (cmd.accept && is_code && !fin_q) begin
				idx_oob_q <= byte_oob;
				if (await_q) begin
					rem_q <= pend_q;
					pend_q <= '0;
					await_q <= 1'b0;
				end else if (marker) begin
					pend_q <= code_byte[pcxd_pkg::RUN_W-1:0] & pcxd_pkg::COUNT_MASK;
					await_q <= 1'b1;
				end else begin
					rem_q <= pcxd_pkg::RUN_W'(1);
				end
			end
			if (cmd.step) begin
				if (row_done) begin
					fin_q <= 1'b1;
				end else begin
					rem_q <= rem_q - pcxd_pkg::RUN_W'(1);
					if (line_end) begin
						col_q <= '0;
						row_q <= row_inc;
						if (row_inc >= height_q) begin
							fin_q <= 1'b1;
						end
					end else begin
						col_q <= x_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.step && emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && emit) begin
			red <= color[23:16];
			green <= color[15:8];
			blue <= color[7:0];
			column <= col_q[pcxd_pkg::COORD_BITS-1:0];
			row <= row_q[pcxd_pkg::COORD_BITS-1:0];
			// no visible column is left for this beat once the next one is cropped
			run_last <= last_step || (x_inc >= vis);
			image_done <= (row_inc == height_q) && (x_inc == vis);
		end
	end

endmodule
`default_nettype wire

### sv/pcxd_checker.sv
// port-level checker for the pcx palette decoder and its bind
`default_nettype none
module pcxd_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              action,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [7:0]                        red,
	input wire logic [7:0]                        green,
	input wire logic [7:0]                        blue,
	input wire logic [pcxd_pkg::COORD_BITS-1:0]   column,
	input wire logic [pcxd_pkg::COORD_BITS-1:0]   row,
	input wire logic                              run_last,
	input wire logic                              image_done
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({red, green, blue, column, row, run_last, image_done}))
		else $error("output beat changed while stalled");

	// the last pixel of the image is always the last of its run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> run_last)
		else $error("image_done without run_last");

	// a palette load never blocks the next beat
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == pcxd_pkg::ACT_PALETTE |=> in_ready)
		else $error("input stalled after a palette load");

	// while a run still has visible pixels to come, no input is taken
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !in_ready)
		else $error("input ready in the middle of a run");

endmodule

bind pcx_rle_palette_decoder_core pcxd_checker u_chk (.*);
`default_nettype wire
